// ----- rtl/core/fpdb_pkg.sv -----
// Shared types, widths and constants for the feedback power report block.
package fpdb_pkg;

   localparam int ANT_W                 = 12;
   localparam int RAW_W                 = 32;
   localparam int REPORT_W              = 13;
   localparam int MANT_W                = 32;
   localparam int EXP_W                 = 5;
   localparam int SCALE_SHIFT           = 24;
   localparam int SCALE_W               = 29;
   localparam int Q_W                   = 11;
   localparam int SUM_W                 = 14;
   localparam int FRAC_BITS_DEFAULT     = 16;
   localparam int READING_WIDTH_DEFAULT = 32;

   localparam logic [SCALE_W-1:0] LOG10_2_X100 = 29'd505044526;

   localparam logic signed [SUM_W-1:0] REPORT_MAX = 14'sd4095;
   localparam logic signed [SUM_W-1:0] REPORT_MIN = -14'sd4096;

   typedef struct packed {
      logic signed [ANT_W-1:0] antenna_power;
      logic [RAW_W-1:0]        ref_power;
      logic [RAW_W-1:0]        fb_power;
   } req_type;

   typedef struct packed {
      logic signed [REPORT_W-1:0] fb_power_report;
      logic                       used_fallback;
   } rsp_type;

endpackage

// ----- rtl/core/fpdb_norm.sv -----
// Leading-one search and left normalization of one raw power reading.
module fpdb_norm (
   input  logic [fpdb_pkg::RAW_W-1:0]  raw,
   output logic [fpdb_pkg::MANT_W-1:0] mant,
   output logic [fpdb_pkg::EXP_W-1:0]  expo,
   output logic                        is_zero
);

   logic [fpdb_pkg::EXP_W-1:0] shift;

   always_comb begin
      expo = '0;
      for (int i = 0; i < fpdb_pkg::RAW_W; i++) begin
         if (raw[i]) begin
            expo = fpdb_pkg::EXP_W'(i);
         end
      end
   end

   assign shift   = fpdb_pkg::EXP_W'(fpdb_pkg::MANT_W - 1) - expo;
   assign mant    = fpdb_pkg::MANT_W'(raw) << shift;
   assign is_zero = (raw == '0);

endmodule

// ----- rtl/core/fpdb_sq_step.sv -----
// One fraction bit of the base-two logarithm by squaring the mantissa.
module fpdb_sq_step (
   input  logic [fpdb_pkg::MANT_W-1:0] mant_i,
   output logic [fpdb_pkg::MANT_W-1:0] mant_o,
   output logic                        bit_o
);

   logic [2*fpdb_pkg::MANT_W-1:0] square;
   logic [fpdb_pkg::MANT_W:0]     scaled;

   assign square = (2*fpdb_pkg::MANT_W)'(mant_i) * (2*fpdb_pkg::MANT_W)'(mant_i);
   assign scaled = square[2*fpdb_pkg::MANT_W-1:fpdb_pkg::MANT_W-1];
   assign bit_o  = scaled[fpdb_pkg::MANT_W];
   assign mant_o = bit_o ? scaled[fpdb_pkg::MANT_W:1] : scaled[fpdb_pkg::MANT_W-1:0];

endmodule

// ----- rtl/core/feedback_power_db_report.sv -----
// Top level: feedback power report from the log ratio of two power readings.
// One transaction per cycle is accepted unless rsp_stall backs up the pipeline. The
// pipeline has one normalize stage, FRAC_BITS squaring stages, then difference, scale
// multiply and round stages.
// Each stage holds its data while the stage after it is full and stalled.
// Synchronous reset clears all valid bits; data registers are not reset.
module feedback_power_db_report #(
   parameter int FRAC_BITS     = fpdb_pkg::FRAC_BITS_DEFAULT,
   parameter int READING_WIDTH = fpdb_pkg::READING_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fpdb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fpdb_pkg::rsp_type rsp_data
);

   localparam int NSTAGE = FRAC_BITS + 4;
   localparam int LOG_W  = fpdb_pkg::EXP_W + FRAC_BITS;
   localparam int PROD_W = LOG_W + fpdb_pkg::SCALE_W + 1;
   localparam int RSH    = FRAC_BITS + fpdb_pkg::SCALE_SHIFT;
   localparam int DIFF_S = FRAC_BITS + 1;
   localparam int MUL_S  = FRAC_BITS + 2;
   localparam int OUT_S  = FRAC_BITS + 3;
   localparam logic [fpdb_pkg::RAW_W-1:0] RMASK =
      fpdb_pkg::RAW_W'((64'd1 << READING_WIDTH) - 64'd1);
   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (RSH - 1);

   logic [NSTAGE-1:0] valid_ff;
   logic [NSTAGE-1:0] valid_in;
   logic [NSTAGE-1:0] en;

   logic [fpdb_pkg::MANT_W-1:0]    rm_ff   [FRAC_BITS+1];
   logic [fpdb_pkg::MANT_W-1:0]    fm_ff   [FRAC_BITS+1];
   logic [fpdb_pkg::EXP_W-1:0]     re_ff   [FRAC_BITS+1];
   logic [fpdb_pkg::EXP_W-1:0]     fe_ff   [FRAC_BITS+1];
   logic [FRAC_BITS-1:0]           rf_ff   [FRAC_BITS+1];
   logic [FRAC_BITS-1:0]           ff_ff   [FRAC_BITS+1];
   logic signed [fpdb_pkg::ANT_W-1:0] ant_ff [FRAC_BITS+3];
   logic [FRAC_BITS+2:0]           zero_ff;

   logic [fpdb_pkg::MANT_W-1:0] rm_in, fm_in;
   logic [fpdb_pkg::EXP_W-1:0]  re_in, fe_in;
   logic                        rz_in, fz_in;

   logic [LOG_W-1:0]   lr, lf;
   logic               neg_in, neg_ff, negm_ff;
   logic [LOG_W-1:0]   mag_in, mag_ff;
   logic [PROD_W-1:0]  prod_in, prod_ff;
   logic [PROD_W-1:0]  rounded;
   logic [fpdb_pkg::Q_W-1:0] quot;
   logic signed [fpdb_pkg::SUM_W-1:0] sum;
   fpdb_pkg::rsp_type rsp_in, rsp_ff;

   for (genvar i = 0; i < NSTAGE - 1; i++) begin : g_en
      assign en[i] = !valid_ff[i] || en[i+1];
   end
   assign en[NSTAGE-1] = !valid_ff[NSTAGE-1] || !rsp_stall;
   assign valid_in     = {valid_ff[NSTAGE-2:0], req_valid};
   assign req_stall    = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTAGE; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   fpdb_norm u_norm_ref (
      .raw     (req_data.ref_power & RMASK),
      .mant    (rm_in),
      .expo    (re_in),
      .is_zero (rz_in)
   );

   fpdb_norm u_norm_fb (
      .raw     (req_data.fb_power & RMASK),
      .mant    (fm_in),
      .expo    (fe_in),
      .is_zero (fz_in)
   );

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rm_ff[0]   <= rm_in;
         fm_ff[0]   <= fm_in;
         re_ff[0]   <= re_in;
         fe_ff[0]   <= fe_in;
         rf_ff[0]   <= '0;
         ff_ff[0]   <= '0;
         ant_ff[0]  <= req_data.antenna_power;
         zero_ff[0] <= rz_in || fz_in;
      end
   end

   for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_sq
      logic [fpdb_pkg::MANT_W-1:0] rm_nx, fm_nx;
      logic                        rbit, fbit;

      fpdb_sq_step u_sq_ref (
         .mant_i (rm_ff[k-1]),
         .mant_o (rm_nx),
         .bit_o  (rbit)
      );

      fpdb_sq_step u_sq_fb (
         .mant_i (fm_ff[k-1]),
         .mant_o (fm_nx),
         .bit_o  (fbit)
      );

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rm_ff[k]   <= rm_nx;
            fm_ff[k]   <= fm_nx;
            re_ff[k]   <= re_ff[k-1];
            fe_ff[k]   <= fe_ff[k-1];
            rf_ff[k]   <= {rf_ff[k-1][FRAC_BITS-2:0], rbit};
            ff_ff[k]   <= {ff_ff[k-1][FRAC_BITS-2:0], fbit};
            ant_ff[k]  <= ant_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
         end
      end
   end

   assign lr     = {re_ff[FRAC_BITS], rf_ff[FRAC_BITS]};
   assign lf     = {fe_ff[FRAC_BITS], ff_ff[FRAC_BITS]};
   assign neg_in = lf < lr;
   assign mag_in = neg_in ? (lr - lf) : (lf - lr);

   always_ff @(posedge clock) begin
      if (en[DIFF_S]) begin
         neg_ff          <= neg_in;
         mag_ff          <= mag_in;
         ant_ff[DIFF_S]  <= ant_ff[FRAC_BITS];
         zero_ff[DIFF_S] <= zero_ff[FRAC_BITS];
      end
   end

   assign prod_in = PROD_W'(mag_ff) * PROD_W'(fpdb_pkg::LOG10_2_X100);

   always_ff @(posedge clock) begin
      if (en[MUL_S]) begin
         negm_ff        <= neg_ff;
         prod_ff        <= prod_in;
         ant_ff[MUL_S]  <= ant_ff[DIFF_S];
         zero_ff[MUL_S] <= zero_ff[DIFF_S];
      end
   end

   assign rounded = prod_ff + HALF;
   assign quot    = rounded[RSH +: fpdb_pkg::Q_W];

   always_comb begin
      if (zero_ff[MUL_S]) begin
         sum = fpdb_pkg::SUM_W'(ant_ff[MUL_S]);
      end else if (negm_ff) begin
         sum = fpdb_pkg::SUM_W'(ant_ff[MUL_S])
               - $signed({{(fpdb_pkg::SUM_W - fpdb_pkg::Q_W){1'b0}}, quot});
      end else begin
         sum = fpdb_pkg::SUM_W'(ant_ff[MUL_S])
               + $signed({{(fpdb_pkg::SUM_W - fpdb_pkg::Q_W){1'b0}}, quot});
      end
      if (sum > fpdb_pkg::REPORT_MAX) begin
         sum = fpdb_pkg::REPORT_MAX;
      end else if (sum < fpdb_pkg::REPORT_MIN) begin
         sum = fpdb_pkg::REPORT_MIN;
      end
      rsp_in.fb_power_report = sum[fpdb_pkg::REPORT_W-1:0];
      rsp_in.used_fallback   = zero_ff[MUL_S];
   end

   always_ff @(posedge clock) begin
      if (en[OUT_S]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff[OUT_S];
   assign rsp_data  = rsp_ff;

endmodule

// ----- verif/feedback_power_db_report_test.sv -----
// Self-checking testbench for the feedback power report block, with random flow control.
module feedback_power_db_report_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS     = fpdb_pkg::FRAC_BITS_DEFAULT;
   localparam int READING_WIDTH = fpdb_pkg::READING_WIDTH_DEFAULT;
   localparam int RANDOM_ITEMS  = 1600;
   localparam int DRAIN_CYCLES  = FRAC_BITS + 24;

   typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LIGHT} stall_mode_type;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   fpdb_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   fpdb_pkg::rsp_type rsp_data;

   fpdb_pkg::req_type pending_items[$];
   fpdb_pkg::rsp_type expected_reports[$];

   int burst_left;
   int gap_left;
   int stall_phase;
   stall_mode_type stall_mode;
   int mismatch_count;
   int checked_count;
   int fallback_count;
   int lowest_report  = 4096;
   int highest_report = -4097;

   feedback_power_db_report #(
      .FRAC_BITS     (FRAC_BITS),
      .READING_WIDTH (READING_WIDTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Log2 of a nonzero reading with FRAC_BITS fraction bits, found by repeated squaring.
   function automatic longint unsigned log2_fixed(bit [31:0] reading);
      int                exponent;
      int                i;
      longint unsigned   mantissa;
      longint unsigned   fraction;
      exponent = 31;
      while (exponent > 0 && reading[exponent] == 1'b0)
         exponent--;
      mantissa = {32'd0, reading} << (31 - exponent);
      fraction = 0;
      for (i = 0; i < FRAC_BITS; i++) begin
         mantissa = (mantissa * mantissa) >> 31;
         fraction = fraction << 1;
         if (mantissa >= 64'h1_0000_0000) begin
            fraction = fraction | 64'd1;
            mantissa = mantissa >> 1;
         end
      end
      return (64'(exponent) << FRAC_BITS) | fraction;
   endfunction

   function automatic fpdb_pkg::rsp_type predict_report(fpdb_pkg::req_type item);
      longint unsigned   reading_mask;
      bit [31:0]         ref_reading;
      bit [31:0]         fb_reading;
      longint unsigned   log_fb;
      longint unsigned   log_ref;
      longint unsigned   magnitude;
      longint unsigned   tenths;
      bit                negative;
      int                sum;
      fpdb_pkg::rsp_type report;
      reading_mask = (64'd1 << READING_WIDTH) - 1;
      ref_reading  = 32'(item.ref_power & reading_mask);
      fb_reading   = 32'(item.fb_power & reading_mask);
      if (ref_reading == 0 || fb_reading == 0) begin
         sum = int'(item.antenna_power);
         report.used_fallback = 1'b1;
      end else begin
         log_fb    = log2_fixed(fb_reading);
         log_ref   = log2_fixed(ref_reading);
         negative  = log_fb < log_ref;
         magnitude = negative ? (log_ref - log_fb) : (log_fb - log_ref);
         tenths    = (magnitude * 64'(fpdb_pkg::LOG10_2_X100)
                      + (64'd1 << (FRAC_BITS + fpdb_pkg::SCALE_SHIFT - 1)))
                     >> (FRAC_BITS + fpdb_pkg::SCALE_SHIFT);
         sum = negative ? int'(item.antenna_power) - int'(tenths)
                        : int'(item.antenna_power) + int'(tenths);
         report.used_fallback = 1'b0;
      end
      if (sum > int'(fpdb_pkg::REPORT_MAX))
         sum = int'(fpdb_pkg::REPORT_MAX);
      if (sum < int'(fpdb_pkg::REPORT_MIN))
         sum = int'(fpdb_pkg::REPORT_MIN);
      report.fb_power_report = sum[fpdb_pkg::REPORT_W-1:0];
      return report;
   endfunction

   task automatic add_measurement(int antenna, bit [31:0] ref_reading, bit [31:0] fb_reading);
      fpdb_pkg::req_type item;
      item.antenna_power = antenna[fpdb_pkg::ANT_W-1:0];
      item.ref_power     = ref_reading;
      item.fb_power      = fb_reading;
      pending_items.push_back(item);
   endtask

   function automatic bit [31:0] random_reading();
      bit [31:0] reading;
      if ($urandom_range(0, 11) == 0)
         return 32'd0;
      case ($urandom_range(0, 3))
         0: reading = $urandom;
         1: reading = $urandom >> $urandom_range(0, 31);
         2: reading = 32'd1 << $urandom_range(0, 31);
         default: reading = $urandom_range(1, 16);
      endcase
      return reading;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall)
            expected_reports.push_back(predict_report(req_data));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_phase = 0;
         stall_mode  = STALL_NONE;
      end else begin
         if (stall_phase == 0) begin
            stall_mode  = stall_mode_type'($urandom_range(0, 3));
            stall_phase = $urandom_range(20, 120);
         end else begin
            stall_phase--;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_HALF:  rsp_stall <= $urandom_range(0, 1);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 7) != 0);
            default:     rsp_stall <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      fpdb_pkg::rsp_type wanted;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_count++;
         if (rsp_data.used_fallback)
            fallback_count++;
         if (int'(rsp_data.fb_power_report) < lowest_report)
            lowest_report = int'(rsp_data.fb_power_report);
         if (int'(rsp_data.fb_power_report) > highest_report)
            highest_report = int'(rsp_data.fb_power_report);
         if (expected_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected transaction, report %0d fallback %0b", $realtime,
                        rsp_data.fb_power_report, rsp_data.used_fallback);
         end else begin
            wanted = expected_reports.pop_front();
            if (rsp_data.fb_power_report !== wanted.fb_power_report
                || rsp_data.used_fallback !== wanted.used_fallback) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: mismatch, report %0d fallback %0b, expected %0d fallback %0b",
                           $realtime, rsp_data.fb_power_report, rsp_data.used_fallback,
                           wanted.fb_power_report, wanted.used_fallback);
            end
         end
      end
   end

   initial begin
      int i;
      add_measurement(0, 32'd0, 32'd0);
      add_measurement(2047, 32'd0, 32'd12345);
      add_measurement(-2048, 32'd777, 32'd0);
      add_measurement(-1, 32'd0, 32'hFFFF_FFFF);
      add_measurement(2047, 32'd1, 32'hFFFF_FFFF);
      add_measurement(-2048, 32'hFFFF_FFFF, 32'd1);
      add_measurement(2047, 32'hFFFF_FFFF, 32'd1);
      add_measurement(-2048, 32'd1, 32'hFFFF_FFFF);
      add_measurement(0, 32'd1, 32'd1);
      add_measurement(123, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_measurement(0, 32'd1, 32'd2);
      add_measurement(0, 32'd2, 32'd1);
      add_measurement(0, 32'd1, 32'd10);
      add_measurement(0, 32'd10, 32'd1);
      add_measurement(-5, 32'd3, 32'd7);
      add_measurement(2047, 32'd1, 32'h8000_0000);
      add_measurement(-2048, 32'h8000_0000, 32'd1);
      add_measurement(0, 32'hAAAA_AAAA, 32'h5555_5555);
      add_measurement(0, 32'h5555_5555, 32'hAAAA_AAAA);
      add_measurement(1000, 32'd100, 32'd1_000_000);
      add_measurement(-1000, 32'd1_000_000, 32'd100);
      for (i = 0; i < RANDOM_ITEMS; i++)
         add_measurement(int'($urandom_range(0, 4095)) - 2048, random_reading(),
                         random_reading());

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_items.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d transactions, %0d through the zero reading path.",
               checked_count, fallback_count);
      $display("Reports ranged from %0d to %0d tenths of a dBm.", lowest_report, highest_report);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("feedback_power_db_report_test: done, clean");
      end else begin
         $display("%0d mismatches in total.", mismatch_count);
         $display("feedback_power_db_report_test: done, errors");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Timed out with %0d transactions still pending.",
               pending_items.size() + expected_reports.size());
      $display("feedback_power_db_report_test: done, errors");
      $finish;
   end

endmodule
